@@ design/bctd_pkg.sv @@
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared constants and types of the BC1..BC5 block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bctd_pkg;

  localparam int MAX_DIM   = 16384;
  localparam int DIM_W     = 15;
  localparam int FMT_W     = 3;
  localparam int PIX_W     = 8;
  localparam int HALF_W    = 64;
  localparam int TEXELS    = 16;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int BCOL_W    = COORD_W - 2;
  localparam int BLKN_W    = DIM_W - 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [FMT_W-1:0] FMT_BC1  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BC2  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_BC3  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_BC4U = 3'd3;
  localparam logic [FMT_W-1:0] FMT_BC4S = 3'd4;
  localparam logic [FMT_W-1:0] FMT_BC5U = 3'd5;
  localparam logic [FMT_W-1:0] FMT_BC5S = 3'd6;
  localparam logic [FMT_W-1:0] FMT_NONE = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef logic [3:0][PIX_W-1:0] pal4_t;
  typedef logic [7:0][PIX_W-1:0] pal8_t;

  typedef struct packed {
    logic [HALF_W-1:0] low;
    logic [HALF_W-1:0] high;
    logic [FMT_W-1:0]  fmt;
    logic              punch;
    logic [BCOL_W-1:0] col;
    logic [BCOL_W-1:0] row;
    logic [TEXELS-1:0] mask;
  } blk_t;

  typedef struct packed {
    logic free;
    logic busy;
    logic pending;
  } stat_t;

endpackage

@@ design/bctd_color_lane.sv @@
// ----------------------------------------------------------------------------
// bctd_color_lane
// One color channel: builds the four-entry palette from two endpoints.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bctd_color_lane (
  input  logic                      clk,
  input  logic                      load,
  input  logic [bctd_pkg::PIX_W-1:0] end_a,
  input  logic [bctd_pkg::PIX_W-1:0] end_b,
  input  logic                      four,
  output bctd_pkg::pal4_t           pal
);
  import bctd_pkg::*;

  pal4_t          pal_next;
  logic [PIX_W:0] sum_half;

  // n / 3 for n < 768
  function automatic logic [PIX_W-1:0] div3(input logic [PIX_W+1:0] n);
    logic [23:0] p;
    p = 24'(n) * 24'd2731;
    return p[20:13];
  endfunction

  always_comb begin
    sum_half    = (PIX_W+1)'(end_a) + (PIX_W+1)'(end_b);
    pal_next[0] = end_a;
    pal_next[1] = end_b;
    if (four) begin
      pal_next[2] = div3((PIX_W+2)'({end_a, 1'b0}) + (PIX_W+2)'(end_b));
      pal_next[3] = div3((PIX_W+2)'(end_a) + (PIX_W+2)'({end_b, 1'b0}));
    end else begin
      pal_next[2] = sum_half[PIX_W:1];
      pal_next[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pal <= pal_next;
    end
  end

endmodule

@@ design/bctd_chan_lane.sv @@
// ----------------------------------------------------------------------------
// bctd_chan_lane
// One single-channel half: builds the eight-entry table, mapped to bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bctd_chan_lane (
  input  logic                          clk,
  input  logic                          load,
  input  logic [2*bctd_pkg::PIX_W-1:0]  ends,
  input  logic                          sgn,
  output bctd_pkg::pal8_t               tab
);
  import bctd_pkg::*;

  localparam logic signed [9:0] SN_MAX = 10'sd127;
  localparam logic signed [9:0] SN_MIN = -10'sd127;
  localparam logic signed [9:0] UN_MAX = 10'sd255;

  logic signed [9:0]  e0, e1;
  logic signed [12:0] e0x, e1x;
  logic               seven;
  logic signed [12:0] num7 [1:6];
  logic signed [12:0] num5 [1:4];
  logic signed [9:0]  val  [8];
  logic [PIX_W-1:0]   ub   [8];
  pal8_t              tab_next;

  function automatic logic signed [9:0] get_end(input logic [PIX_W-1:0] b,
                                                input logic s);
    logic signed [9:0] v;
    v = s ? $signed({{2{b[7]}}, b}) : $signed({2'b00, b});
    if (v < SN_MIN) v = SN_MIN;
    return v;
  endfunction

  // truncating n / 7 for |n| < 1792 and n / 5 for |n| < 1280
  function automatic logic signed [9:0] div7(input logic signed [12:0] n);
    logic [11:0] mag;
    logic [22:0] p;
    logic [9:0]  q;
    mag = n[12] ? 12'(-n) : 12'(n);
    p   = 23'(mag) * 23'd2341;
    q   = {2'b00, p[21:14]};
    return n[12] ? 10'(-$signed(q)) : $signed(q);
  endfunction

  function automatic logic signed [9:0] div5(input logic signed [12:0] n);
    logic [11:0] mag;
    logic [22:0] p;
    logic [9:0]  q;
    mag = n[12] ? 12'(-n) : 12'(n);
    p   = 23'(mag) * 23'd1639;
    q   = {2'b00, p[20:13]};
    return n[12] ? 10'(-$signed(q)) : $signed(q);
  endfunction

  always_comb begin
    e0    = get_end(ends[PIX_W-1:0], sgn);
    e1    = get_end(ends[2*PIX_W-1:PIX_W], sgn);
    e0x   = 13'(e0);
    e1x   = 13'(e1);
    seven = e0 > e1;
    for (int k = 1; k <= 6; k++) begin
      num7[k] = $signed(13'(7 - k)) * e0x + $signed(13'(k)) * e1x;
    end
    for (int k = 1; k <= 4; k++) begin
      num5[k] = $signed(13'(5 - k)) * e0x + $signed(13'(k)) * e1x;
    end
    val[0] = e0;
    val[1] = e1;
    for (int k = 1; k <= 6; k++) begin
      if (seven) begin
        val[k+1] = div7(num7[k]);
      end else if (k <= 4) begin
        val[k+1] = div5(num5[k]);
      end else if (k == 5) begin
        val[k+1] = sgn ? SN_MIN : '0;
      end else begin
        val[k+1] = sgn ? SN_MAX : UN_MAX;
      end
    end
    // snorm to byte: u + (u >= 127), u = v + 127
    for (int t = 0; t < 8; t++) begin
      ub[t] = PIX_W'(val[t] + SN_MAX);
      if (sgn) begin
        tab_next[t] = ub[t] + PIX_W'(ub[t] >= PIX_W'(127));
      end else begin
        tab_next[t] = val[t][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tab <= tab_next;
    end
  end

endmodule

@@ design/bctd_merge.sv @@
// ----------------------------------------------------------------------------
// bctd_merge
// Holds one decoded block, merges lane palettes per texel by format and emits
// visible texels via an output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bctd_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  bctd_pkg::blk_t               blk,
  input  bctd_pkg::pal4_t              pal_r,
  input  bctd_pkg::pal4_t              pal_g,
  input  bctd_pkg::pal4_t              pal_b,
  input  bctd_pkg::pal8_t              tab_a,
  input  bctd_pkg::pal8_t              tab_b,
  output bctd_pkg::stat_t              stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bctd_pkg::COORD_W-1:0] pixel_x,
  output logic [bctd_pkg::COORD_W-1:0] pixel_y,
  output logic [bctd_pkg::PIX_W-1:0]   red,
  output logic [bctd_pkg::PIX_W-1:0]   green,
  output logic [bctd_pkg::PIX_W-1:0]   blue,
  output logic [bctd_pkg::PIX_W-1:0]   alpha,
  output logic                         last
);
  import bctd_pkg::*;

  logic              s2_valid;
  blk_t              cur;
  logic [TEXELS-1:0] rem, rem_next;
  logic [3:0]        idx;
  logic              step, done;
  logic [HALF_W-1:0] chalf;
  logic [31:0]       cbits;
  logic [47:0]       abits, bbits;
  logic [1:0]        cidx;
  logic [2:0]        aidx, bidx;
  logic [5:0]        sel3;
  logic [3:0]        a4;
  logic [PIX_W-1:0]  r_v, g_v, b_v, a_v;

  always_comb begin
    idx = '0;
    for (int i = TEXELS - 1; i >= 0; i--) begin
      if (rem[i]) idx = 4'(i);
    end
    rem_next = rem & ~(TEXELS'(1) << idx);
    done     = rem_next == '0;
    step     = s2_valid && (!out_valid || out_ready);
  end

  always_comb begin
    chalf = (cur.fmt == FMT_BC1) ? cur.low : cur.high;
    cbits = chalf[63:32];
    abits = cur.low[63:16];
    bbits = cur.high[63:16];
    sel3  = {2'b00, idx} * 6'd3;
    cidx  = cbits[{idx, 1'b0} +: 2];
    aidx  = abits[sel3 +: 3];
    bidx  = bbits[sel3 +: 3];
    a4    = cur.low[{idx, 2'b00} +: 4];
    r_v   = pal_r[cidx];
    g_v   = pal_g[cidx];
    b_v   = pal_b[cidx];
    a_v   = '1;
    case (cur.fmt)
      FMT_BC1: begin
        if (cur.punch && cidx == 2'd3) a_v = '0;
      end
      FMT_BC2: begin
        a_v = {a4, a4};
      end
      FMT_BC3: begin
        a_v = tab_a[aidx];
      end
      FMT_BC4U, FMT_BC4S: begin
        r_v = tab_a[aidx];
        g_v = tab_a[aidx];
        b_v = tab_a[aidx];
      end
      FMT_BC5U, FMT_BC5S: begin
        r_v = tab_a[aidx];
        g_v = tab_b[bidx];
        b_v = '0;
      end
      default: begin
        r_v = '0;
        g_v = '0;
        b_v = '0;
        a_v = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s2_valid <= 1'b1;
      end else if (step && done) begin
        s2_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= blk;
      rem <= blk.mask;
    end else if (step) begin
      rem <= rem_next;
    end
    if (step) begin
      pixel_x <= {cur.col, idx[1:0]};
      pixel_y <= {cur.row, idx[3:2]};
      red     <= r_v;
      green   <= g_v;
      blue    <= b_v;
      alpha   <= a_v;
      last    <= done;
    end
  end

  assign stat.free    = !s2_valid || (step && done);
  assign stat.busy    = s2_valid;
  assign stat.pending = rem != '0;

endmodule

@@ design/bc_texture_block_decoder.sv @@
// ----------------------------------------------------------------------------
// bc_texture_block_decoder
// Decodes BC1..BC5 4x4 blocks in raster block order to RGBA8 texels.
// A block is registered on acceptance, then loaded into the decode stage when
// it is free; texels leave via an output register, one word per cycle unless
// out_ready stalls them. A block holds the decode stage until its visible
// texels (16 for interior blocks) are out; blocks with none skip that stage.
// Reset clears block counters and valids, and sets format BC1, size 1x1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc_texture_block_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bctd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bctd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bctd_pkg::HALF_W-1:0]    block_low,
  input  logic [bctd_pkg::HALF_W-1:0]    block_high,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bctd_pkg::COORD_W-1:0]   pixel_x,
  output logic [bctd_pkg::COORD_W-1:0]   pixel_y,
  output logic [bctd_pkg::PIX_W-1:0]     red,
  output logic [bctd_pkg::PIX_W-1:0]     green,
  output logic [bctd_pkg::PIX_W-1:0]     blue,
  output logic [bctd_pkg::PIX_W-1:0]     alpha,
  output logic                           last
);
  import bctd_pkg::*;

  logic [FMT_W-1:0]  texture_format;
  logic [DIM_W-1:0]  image_width, image_height;
  logic [DIM_W-1:0]  width_eff, height_eff, wsum, hsum;
  logic [BLKN_W-1:0] blocks_wide, blocks_high, col_inc, row_inc;
  logic [BCOL_W-1:0] block_column, block_row;
  logic [3:0]        x_in, y_in;
  logic [TEXELS-1:0] mask_new;
  logic              in_fire;

  logic              s1_valid, s1_take, s2_load;
  blk_t              s1_blk, s2_blk;
  logic [HALF_W-1:0] chalf;
  logic [15:0]       c0, c1;
  logic              four, sgn;
  stat_t             m_stat;
  pal4_t             pal_r, pal_g, pal_b;
  pal8_t             tab_a, tab_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_BC1;
      image_width    <= DIM_W'(1);
      image_height   <= DIM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT: texture_format <= cfg_data[FMT_W-1:0];
        REG_WIDTH:  image_width    <= cfg_data;
        REG_HEIGHT: image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff  = (image_width == '0) ? DIM_W'(1) :
                 (image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
    height_eff = (image_height == '0) ? DIM_W'(1) :
                 (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
    wsum        = width_eff + DIM_W'(3);
    hsum        = height_eff + DIM_W'(3);
    blocks_wide = wsum[DIM_W-1:2];
    blocks_high = hsum[DIM_W-1:2];
    col_inc     = BLKN_W'(block_column) + BLKN_W'(1);
    row_inc     = BLKN_W'(block_row) + BLKN_W'(1);
    for (int j = 0; j < 4; j++) begin
      x_in[j] = DIM_W'({block_column, 2'(j)}) < width_eff;
      y_in[j] = DIM_W'({block_row, 2'(j)}) < height_eff;
    end
    for (int i = 0; i < TEXELS; i++) begin
      mask_new[i] = x_in[i%4] && y_in[i/4] && (texture_format != FMT_NONE);
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign s1_take  = s1_valid && (s1_blk.mask == '0 || m_stat.free);
  assign s2_load  = s1_valid && s1_blk.mask != '0 && m_stat.free;
  assign in_ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        if (col_inc >= blocks_wide) begin
          block_column <= '0;
          if (row_inc >= blocks_high) begin
            block_row <= '0;
          end else begin
            block_row <= row_inc[BCOL_W-1:0];
          end
        end else begin
          block_column <= col_inc[BCOL_W-1:0];
        end
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_blk.low   <= block_low;
      s1_blk.high  <= block_high;
      s1_blk.fmt   <= texture_format;
      s1_blk.punch <= 1'b0;
      s1_blk.col   <= block_column;
      s1_blk.row   <= block_row;
      s1_blk.mask  <= mask_new;
    end
  end

  always_comb begin
    chalf = (s1_blk.fmt == FMT_BC1) ? s1_blk.low : s1_blk.high;
    c0    = chalf[15:0];
    c1    = chalf[31:16];
    four  = (s1_blk.fmt != FMT_BC1) || (c0 > c1);
    sgn   = (s1_blk.fmt == FMT_BC4S) || (s1_blk.fmt == FMT_BC5S);
    s2_blk       = s1_blk;
    s2_blk.punch = (s1_blk.fmt == FMT_BC1) && !four;
  end

  bctd_color_lane u_lane_r (
    .clk   (clk),
    .load  (s2_load),
    .end_a ({c0[15:11], c0[15:13]}),
    .end_b ({c1[15:11], c1[15:13]}),
    .four  (four),
    .pal   (pal_r)
  );

  bctd_color_lane u_lane_g (
    .clk   (clk),
    .load  (s2_load),
    .end_a ({c0[10:5], c0[10:9]}),
    .end_b ({c1[10:5], c1[10:9]}),
    .four  (four),
    .pal   (pal_g)
  );

  bctd_color_lane u_lane_b (
    .clk   (clk),
    .load  (s2_load),
    .end_a ({c0[4:0], c0[4:2]}),
    .end_b ({c1[4:0], c1[4:2]}),
    .four  (four),
    .pal   (pal_b)
  );

  bctd_chan_lane u_lane_ta (
    .clk  (clk),
    .load (s2_load),
    .ends (s1_blk.low[15:0]),
    .sgn  (sgn),
    .tab  (tab_a)
  );

  bctd_chan_lane u_lane_tb (
    .clk  (clk),
    .load (s2_load),
    .ends (s1_blk.high[15:0]),
    .sgn  (sgn),
    .tab  (tab_b)
  );

  bctd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (s2_load),
    .blk       (s2_blk),
    .pal_r     (pal_r),
    .pal_g     (pal_g),
    .pal_b     (pal_b),
    .tab_a     (tab_a),
    .tab_b     (tab_b),
    .stat      (m_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .last      (last)
  );

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> m_stat.busy)
    else $error("decode stage not busy after block load");

  a_busy_pending: assert property (@(posedge clk) disable iff (rst)
    m_stat.busy |-> m_stat.pending)
    else $error("decode stage busy with no texels left");

  a_last_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> m_stat.busy)
    else $error("block retired before its last texel");

endmodule

@@ tb/bc_texture_block_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// bc_texture_block_decoder_checker
// Watches the config, block and texel channels of the BC1..BC5 decoder,
// decodes every accepted block with its own copy of the registers and block
// counters, and compares each texel word in order against the oldest
// prediction. Reports the running mismatch count and the number of texels
// still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc_texture_block_decoder_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bctd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bctd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [bctd_pkg::HALF_W-1:0]    block_low,
  input  logic [bctd_pkg::HALF_W-1:0]    block_high,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [bctd_pkg::COORD_W-1:0]   pixel_x,
  input  logic [bctd_pkg::COORD_W-1:0]   pixel_y,
  input  logic [bctd_pkg::PIX_W-1:0]     red,
  input  logic [bctd_pkg::PIX_W-1:0]     green,
  input  logic [bctd_pkg::PIX_W-1:0]     blue,
  input  logic [bctd_pkg::PIX_W-1:0]     alpha,
  input  logic                           last,
  output int                             mismatches,
  output int                             pending
);

  import bctd_pkg::*;

  typedef logic [TEXELS-1:0][PIX_W-1:0] chan16_t;

  typedef struct packed {
    chan16_t r;
    chan16_t g;
    chan16_t b;
    chan16_t a;
  } block_rgba_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   r;
    logic [PIX_W-1:0]   g;
    logic [PIX_W-1:0]   b;
    logic [PIX_W-1:0]   a;
    logic               last;
  } texel_t;

  texel_t           expected_texels[$];
  texel_t           want;
  logic [FMT_W-1:0] fmt_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int               blk_col;
  int               blk_row;
  int               errors = 0;

  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // 565 to 888 by bit replication, packed as {r, g, b}
  function automatic logic [23:0] expand565(logic [15:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  function automatic block_rgba_t color_half(logic [63:0] v, bit three_ok);
    block_rgba_t res;
    logic [23:0] ea;
    logic [23:0] eb;
    int          a[3];
    int          b[3];
    int          pal[4][4];
    int          ch;
    int          i;
    int          k;
    ea = expand565(v[15:0]);
    eb = expand565(v[31:16]);
    for (ch = 0; ch < 3; ch++) begin
      a[ch] = int'(ea[23 - 8 * ch -: 8]);
      b[ch] = int'(eb[23 - 8 * ch -: 8]);
      pal[0][ch] = a[ch];
      pal[1][ch] = b[ch];
    end
    pal[0][3] = 255;
    pal[1][3] = 255;
    if (!three_ok || v[15:0] > v[31:16]) begin
      for (ch = 0; ch < 3; ch++) begin
        pal[2][ch] = (2 * a[ch] + b[ch]) / 3;
        pal[3][ch] = (a[ch] + 2 * b[ch]) / 3;
      end
      pal[2][3] = 255;
      pal[3][3] = 255;
    end else begin
      // three colours plus transparent black
      for (ch = 0; ch < 3; ch++) begin
        pal[2][ch] = (a[ch] + b[ch]) / 2;
        pal[3][ch] = 0;
      end
      pal[2][3] = 255;
      pal[3][3] = 0;
    end
    for (i = 0; i < TEXELS; i++) begin
      k = int'(v[32 + 2 * i +: 2]);
      res.r[i] = 8'(pal[k][0]);
      res.g[i] = 8'(pal[k][1]);
      res.b[i] = 8'(pal[k][2]);
      res.a[i] = 8'(pal[k][3]);
    end
    return res;
  endfunction

  function automatic logic [7:0] snorm_byte(int v);
    int c;
    c = v;
    if (c < -127) c = -127;
    if (c > 127) c = 127;
    c = ((c + 127) * 255 + 127) / 254;
    return c[7:0];
  endfunction

  function automatic chan16_t channel_half(logic [63:0] v, bit sgn);
    chan16_t res;
    int      t[8];
    int      e0;
    int      e1;
    int      i;
    int      val;
    e0 = int'(v[7:0]);
    e1 = int'(v[15:8]);
    if (sgn) begin
      if (e0 >= 128) e0 -= 256;
      if (e1 >= 128) e1 -= 256;
      if (e0 < -127) e0 = -127;
      if (e1 < -127) e1 = -127;
    end
    t[0] = e0;
    t[1] = e1;
    if (e0 > e1) begin
      for (i = 1; i <= 6; i++) t[i + 1] = ((7 - i) * e0 + i * e1) / 7;
    end else begin
      for (i = 1; i <= 4; i++) t[i + 1] = ((5 - i) * e0 + i * e1) / 5;
      t[6] = sgn ? -127 : 0;
      t[7] = sgn ? 127 : 255;
    end
    for (i = 0; i < TEXELS; i++) begin
      val = t[v[16 + 3 * i +: 3]];
      res[i] = sgn ? snorm_byte(val) : val[7:0];
    end
    return res;
  endfunction

  task automatic decode_block(logic [63:0] lo, logic [63:0] hi);
    block_rgba_t px;
    chan16_t     ch_r;
    chan16_t     ch_g;
    texel_t      tx;
    bit          emits;
    bit          sgn;
    bit          two;
    int          w;
    int          h;
    int          bw;
    int          bh;
    int          i;
    int          x;
    int          y;
    int          last_vis;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    bw = (w + 3) / 4;
    bh = (h + 3) / 4;
    emits = 1'b1;
    px = '0;
    case (fmt_reg)
      FMT_BC1: px = color_half(lo, 1'b1);
      FMT_BC2: begin
        px = color_half(hi, 1'b0);
        for (i = 0; i < TEXELS; i++) px.a[i] = {4'b0, lo[4 * i +: 4]} * 8'd17;
      end
      FMT_BC3: begin
        px = color_half(hi, 1'b0);
        px.a = channel_half(lo, 1'b0);
      end
      FMT_BC4U, FMT_BC4S, FMT_BC5U, FMT_BC5S: begin
        sgn = (fmt_reg == FMT_BC4S) || (fmt_reg == FMT_BC5S);
        two = (fmt_reg == FMT_BC5U) || (fmt_reg == FMT_BC5S);
        ch_r = channel_half(lo, sgn);
        ch_g = two ? channel_half(hi, sgn) : ch_r;
        px.r = ch_r;
        px.g = ch_g;
        px.b = two ? '0 : ch_r;
        px.a = {TEXELS{8'hFF}};
      end
      default: emits = 1'b0;
    endcase

    if (emits) begin
      last_vis = -1;
      for (i = 0; i < TEXELS; i++) begin
        x = blk_col * 4 + (i % 4);
        y = blk_row * 4 + (i / 4);
        if (x < w && y < h) last_vis = i;
      end
      for (i = 0; i < TEXELS; i++) begin
        x = blk_col * 4 + (i % 4);
        y = blk_row * 4 + (i / 4);
        if (x < w && y < h) begin
          tx.x = COORD_W'(x);
          tx.y = COORD_W'(y);
          tx.r = px.r[i];
          tx.g = px.g[i];
          tx.b = px.b[i];
          tx.a = px.a[i];
          tx.last = (i == last_vis);
          expected_texels.push_back(tx);
        end
      end
    end

    if (blk_col + 1 >= bw) begin
      blk_col = 0;
      if (blk_row + 1 >= bh) blk_row = 0;
      else blk_row++;
    end else begin
      blk_col++;
    end
  endtask

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_texels.delete();
      fmt_reg = FMT_BC1;
      width_reg = DIM_W'(1);
      height_reg = DIM_W'(1);
      blk_col = 0;
      blk_row = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORMAT: fmt_reg = cfg_data[FMT_W-1:0];
          REG_WIDTH:  width_reg = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_block(block_low, block_high);
      if (out_valid && out_ready) begin
        if (expected_texels.size() == 0) begin
          $error("unexpected texel word at x %0d y %0d", pixel_x, pixel_y);
          errors++;
        end else begin
          want = expected_texels.pop_front();
          check_field("pixel_x", int'(want.x), int'(pixel_x));
          check_field("pixel_y", int'(want.y), int'(pixel_y));
          check_field("red", int'(want.r), int'(red));
          check_field("green", int'(want.g), int'(green));
          check_field("blue", int'(want.b), int'(blue));
          check_field("alpha", int'(want.a), int'(alpha));
          check_field("last", int'(want.last), int'(last));
        end
      end
    end
    mismatches <= errors;
    pending <= expected_texels.size();
  end

endmodule

@@ tb/bc_texture_block_decoder_test.sv @@
// ----------------------------------------------------------------------------
// bc_texture_block_decoder_test
// Stimulus for the BC1..BC5 block decoder: a directed set of blocks per
// format and image shape, then random blocks under random formats and image
// sizes, with random gaps on the block and texel channels and one long texel
// stall. Texel words are checked by the checker instance; the verdict is
// given here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc_texture_block_decoder_test;

  import bctd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LIMIT        = 1500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 500;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [HALF_W-1:0]    block_low = '0;
  logic [HALF_W-1:0]    block_high = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   pixel_x;
  logic [COORD_W-1:0]   pixel_y;
  logic [PIX_W-1:0]     red;
  logic [PIX_W-1:0]     green;
  logic [PIX_W-1:0]     blue;
  logic [PIX_W-1:0]     alpha;
  logic                 last;

  int   mismatches;
  int   pending;
  int   cycles = 0;
  logic hold_armed = 1'b0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  int   rx_gap = 0;
  int   rx_hold = 0;
  int   rx_cycles = 0;

  bc_texture_block_decoder DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .block_low(block_low), .block_high(block_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .red(red), .green(green), .blue(blue), .alpha(alpha), .last(last)
  );

  bc_texture_block_decoder_checker texel_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .block_low(block_low), .block_high(block_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .red(red), .green(green), .blue(blue), .alpha(alpha), .last(last),
    .mismatches(mismatches), .pending(pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 0;
      1: return MAX_DIM;
      2: return 32767;
      3: return MAX_DIM + 1;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // texel receiver: random gaps, calm stretches, one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_armed && rx_hold < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        rx_hold++;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        rx_gap = rx_calm ? 0 : draw_gap();
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every predicted texel, then let empty blocks drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [FMT_W-1:0] fmt, int w, int h);
    settle();
    write_reg(REG_FORMAT, DIM_W'(fmt));
    write_reg(REG_WIDTH, DIM_W'(w));
    write_reg(REG_HEIGHT, DIM_W'(h));
  endtask

  task automatic send_block(logic [63:0] lo, logic [63:0] hi);
    int gap;
    gap = tx_calm ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    block_low <= lo;
    block_high <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [FMT_W-1:0] fmt;
    logic [63:0]      lo;
    logic [63:0]      hi;
    int               counted;
    int               n_items;
    int               k;
    bit               first;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // four-colour, three-colour, equal endpoints, all one
    configure(FMT_BC1, 4, 4);
    write_reg(REG_SPARE, 15'h7FFF);
    send_block(64'hE4E4E4E4_0000_FFFF, 64'h0);
    send_block(64'hE4E4E4E4_FFFF_0000, 64'h0);
    send_block(64'h1B1B1B1B_1234_1234, 64'h0);
    send_block(64'hFFFFFFFF_FFFF_FFFF, 64'hFFFFFFFF_FFFF_FFFF);

    configure(FMT_BC2, 4, 4);
    send_block(64'hFEDCBA98_76543210, 64'hE4E4E4E4_FFFF_0000);
    send_block(64'h0, 64'hE4E4E4E4_0000_FFFF);
    send_block(64'hFFFFFFFF_FFFFFFFF, 64'h0);

    configure(FMT_BC3, 4, 4);
    send_block(64'hFAC688FA_C688_00FF, 64'hE4E4E4E4_0000_FFFF);
    send_block(64'hFAC688FA_C688_FF00, 64'h1B1B1B1B_1234_1234);
    send_block(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);

    configure(FMT_BC4U, 4, 4);
    send_block(64'hFAC688FA_C688_00FF, 64'h0);
    send_block(64'hFAC688FA_C688_FF00, 64'h0);

    // signed: -128 clamps to -127
    configure(FMT_BC4S, 4, 4);
    send_block(64'hFAC688FA_C688_7F80, 64'h0);
    send_block(64'hFAC688FA_C688_817F, 64'h0);

    configure(FMT_BC5U, 4, 4);
    send_block(64'hFAC688FA_C688_00FF, 64'hFAC688FA_C688_FF00);

    configure(FMT_BC5S, 4, 4);
    send_block(64'hFAC688FA_C688_8080, 64'hFAC688FA_C688_7F80);
    send_block(64'hFAC688FA_C688_817F, 64'hFAC688FA_C688_0000);

    configure(FMT_NONE, 4, 4);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);

    // partial edge blocks
    configure(FMT_BC1, 5, 6);
    for (k = 0; k < 4; k++) send_block({$urandom, $urandom}, {$urandom, $urandom});

    // zero size reads as 1x1
    configure(FMT_BC4U, 0, 0);
    send_block({$urandom, $urandom}, 64'h0);

    // oversized width, then counters left past a narrower image
    configure(FMT_BC4U, 32767, 3);
    send_block({$urandom, $urandom}, 64'h0);
    send_block({$urandom, $urandom}, 64'h0);
    configure(FMT_BC2, 4, 8);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    send_block({$urandom, $urandom}, {$urandom, $urandom});

    counted = 0;
    first = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      if (first) begin
        fmt = FMT_BC1;
        configure(fmt, 64, 64);
        hold_armed <= 1'b1;
        first = 1'b0;
      end else begin
        fmt = ($urandom_range(0, 15) == 0) ? FMT_NONE : FMT_W'($urandom_range(0, 6));
        configure(fmt, pick_dim(), pick_dim());
      end
      n_items = $urandom_range(20, 60);
      for (k = 0; k < n_items; k++) begin
        if (k % 16 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) lo[31:16] = lo[15:0];
        if ($urandom_range(0, 7) == 0) hi[31:16] = hi[15:0];
        if ($urandom_range(0, 7) == 0) lo[7:0] = 8'h80;
        if ($urandom_range(0, 7) == 0) hi[15:8] = 8'h80;
        send_block(lo, hi);
        if (fmt != FMT_NONE) counted++;
      end
      fmt = FMT_BC1;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bctd_pkg.sv
design/bctd_color_lane.sv
design/bctd_chan_lane.sv
design/bctd_merge.sv
design/bc_texture_block_decoder.sv
tb/bc_texture_block_decoder_checker.sv
tb/bc_texture_block_decoder_test.sv
